### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/frm_pkg.sv
// ----------------------------------------------------------------------------
// frm_pkg
// Shared constants, codes and helpers of the fragment message reassembler.
// ----------------------------------------------------------------------------
package frm_pkg;

  localparam int MAX_FRAGMENTS_DEF = 16;
  localparam int NUM_CONTEXTS_DEF  = 64;
  localparam int PAYLOAD_BYTES_DEF = 8;

  localparam logic [15:0] STALE_TIMEOUT_RST = 16'd100;

  localparam logic [1:0] OP_FRAME    = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_PURGE    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [1:0] FT_SINGLE = 2'd0;
  localparam logic [1:0] FT_FIRST  = 2'd1;
  localparam logic [1:0] FT_MIDDLE = 2'd2;
  localparam logic [1:0] FT_LAST   = 2'd3;

  localparam logic REG_STALE_TIMEOUT = 1'b0;

  // Keep the low n bytes of a word, zero the rest.
  function automatic logic [63:0] keep_bytes(input logic [63:0] data, input logic [3:0] n);
    logic [63:0] res;
    res = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) begin
        res[b*8 +: 8] = data[b*8 +: 8];
      end
    end
    return res;
  endfunction

endpackage

### sv/frm_in_if.sv
// ----------------------------------------------------------------------------
// frm_in_if
// Input request channel: frames, ticks and purges.
// ----------------------------------------------------------------------------
interface frm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [1:0]  fragment_type;
  logic        direction;
  logic [2:0]  board_address;
  logic [2:0]  device_id;
  logic [7:0]  command;
  logic [7:0]  fragment_count;
  logic [63:0] payload;
  logic [3:0]  data_len;

  modport source (output valid, op, fragment_type, direction, board_address, device_id,
                  command, fragment_count, payload, data_len, input ready);
  modport sink (input valid, op, fragment_type, direction, board_address, device_id,
                command, fragment_count, payload, data_len, output ready);
endinterface

### sv/frm_out_if.sv
// ----------------------------------------------------------------------------
// frm_out_if
// Output request channel: one delivered fragment per request.
// ----------------------------------------------------------------------------
interface frm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_board_address;
  logic [2:0]  out_device_id;
  logic        out_direction;
  logic [7:0]  out_command;
  logic [63:0] out_data;
  logic [3:0]  byte_count;
  logic        last;

  modport source (output valid, out_board_address, out_device_id, out_direction,
                  out_command, out_data, byte_count, last, input ready);
  modport sink (input valid, out_board_address, out_device_id, out_direction,
                out_command, out_data, byte_count, last, output ready);
endinterface

### sv/frm_ram.sv
// ----------------------------------------------------------------------------
// frm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module frm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/fragment_message_reassembler.sv
// ----------------------------------------------------------------------------
// fragment_message_reassembler
// Reassembles multi-frame bus messages per board/device context.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per frame, tick or purge; out_ch carries one
//   request per delivered fragment, with last marking the end of a message.
//   The APB port holds stale_timeout at byte address 0.
// Sequence (one request at a time, set by the sequencer and its RAM ports):
//   tick or unused op: handled in ST_IDLE. Single frame: result loaded in
//   ST_FINAL. First or middle frame: context read, then write back. Completing
//   last frame: context read and check, then per stored fragment a read through
//   the registered fragment RAM port and a load, then ST_FINAL. Purge: a read
//   and a check per context through the context RAM port.
// Reset:
//   A clearing pass writes every context invalid; in_ch.ready stays low
//   meanwhile. Configuration writes are taken anyway.
// Stall:
//   One output register parts the sides. A new request is accepted while a
//   result waits; the sequencer holds before loading the next result until
//   the output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fragment_message_reassembler #(
  parameter int MAX_FRAGMENTS = frm_pkg::MAX_FRAGMENTS_DEF,
  parameter int NUM_CONTEXTS  = frm_pkg::NUM_CONTEXTS_DEF,
  parameter int PAYLOAD_BYTES = frm_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  frm_in_if.sink      in_ch,
  frm_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CTX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int FA_W  = $clog2(NUM_CONTEXTS * MAX_FRAGMENTS);
  localparam int FC_W  = $clog2(MAX_FRAGMENTS + 2);
  localparam int CW_W  = 1 + 8 + FC_W + FC_W + 1 + 32;
  localparam int FW_W  = 4 + 64;

  typedef struct packed {
    logic            valid;
    logic [7:0]      command;
    logic [FC_W-1:0] expected;
    logic [FC_W-1:0] received;
    logic            direction;
    logic [31:0]     last_activity;
  } ctx_word_t;

  typedef enum logic [8:0] {
    ST_CLEAR     = 9'b000000001,
    ST_IDLE      = 9'b000000010,
    ST_LOOK      = 9'b000000100,
    ST_EMIT_RD   = 9'b000001000,
    ST_EMIT_WR   = 9'b000010000,
    ST_FINAL     = 9'b000100000,
    ST_PURGE_RD  = 9'b001000000,
    ST_PURGE_CHK = 9'b010000000,
    ST_SPARE     = 9'b100000000
  } state_t;

  state_t state;

  logic [31:0] time_now;
  logic [15:0] stale_timeout;

  // Latched request
  logic [1:0]  ftype;
  logic        dir;
  logic [2:0]  board;
  logic [2:0]  dev;
  logic [7:0]  cmd;
  logic [7:0]  fcount;
  logic [63:0] payload;
  logic [3:0]  len;
  logic [CTX_W-1:0] ctx_idx;

  logic [CTX_W-1:0] sweep;
  logic [FC_W-1:0]  emit_idx;
  logic [FC_W-1:0]  emit_cnt;
  logic             emit_dir;

  // Output register
  logic        ov;
  logic [63:0] o_data;
  logic [3:0]  o_count;
  logic        o_last;
  logic        o_dir;
  logic [2:0]  o_board;
  logic [2:0]  o_dev;
  logic [7:0]  o_cmd;

  // RAM ports
  logic             ctx_we;
  logic [CTX_W-1:0] ctx_waddr;
  ctx_word_t        ctx_wdata;
  logic [CTX_W-1:0] ctx_raddr;
  logic [CW_W-1:0]  ctx_rdata;
  logic             frag_we;
  logic [FA_W-1:0]  frag_waddr;
  logic [FW_W-1:0]  frag_wdata;
  logic [FA_W-1:0]  frag_raddr;
  logic [FW_W-1:0]  frag_rdata;

  frm_ram #(.DEPTH(NUM_CONTEXTS), .WIDTH(CW_W)) u_ctx_ram (
    .clk   (clk),
    .we    (ctx_we),
    .waddr (ctx_waddr),
    .wdata (ctx_wdata),
    .raddr (ctx_raddr),
    .rdata (ctx_rdata)
  );

  frm_ram #(.DEPTH(NUM_CONTEXTS * MAX_FRAGMENTS), .WIDTH(FW_W)) u_frag_ram (
    .clk   (clk),
    .we    (frag_we),
    .waddr (frag_waddr),
    .wdata (frag_wdata),
    .raddr (frag_raddr),
    .rdata (frag_rdata)
  );

  // Context index of the incoming request: key modulo the context count
  logic [5:0]       in_key;
  logic [CTX_W-1:0] in_ctx;
  assign in_key = {in_ch.board_address, in_ch.device_id};
  always_comb begin
    in_ctx = '0;
    for (int k = 0; k < 64; k++) begin
      if (in_key == 6'(k)) begin
        in_ctx = CTX_W'(k % NUM_CONTEXTS);
      end
    end
  end

  logic      in_acc;
  logic      out_free;
  logic      load_out;
  ctx_word_t cw;
  logic [3:0]      len_c;
  logic [3:0]      trim;
  logic [FC_W-1:0] r_next;
  logic [FA_W-1:0] frag_base;
  logic            first_ok;
  logic            mid_over;
  logic            last_ok;
  logic            stale;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !ov || out_ch.ready;
  assign load_out    = (state == ST_EMIT_WR) || ((state == ST_FINAL) && out_free);

  assign cw        = ctx_word_t'(ctx_rdata);
  assign len_c     = (len > 4'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES) : len;
  assign trim      = (fcount < {4'b0, len_c}) ? fcount[3:0] : len_c;
  assign r_next    = cw.received + FC_W'(1);
  assign frag_base = FA_W'(ctx_idx) * FA_W'(MAX_FRAGMENTS);
  assign first_ok  = fcount <= 8'(MAX_FRAGMENTS);
  assign mid_over  = (r_next > cw.expected) || (r_next > FC_W'(MAX_FRAGMENTS));
  assign last_ok   = (r_next == cw.expected) && (r_next <= FC_W'(MAX_FRAGMENTS)) &&
                     (r_next >= FC_W'(1));
  assign stale     = cw.valid && ((time_now - cw.last_activity) > {16'b0, stale_timeout});

  // RAM access per sequencer step
  always_comb begin
    ctx_we     = 1'b0;
    ctx_waddr  = ctx_idx;
    ctx_wdata  = cw;
    ctx_raddr  = ctx_idx;
    frag_we    = 1'b0;
    frag_waddr = frag_base;
    frag_wdata = {len_c, frm_pkg::keep_bytes(payload, len_c)};
    frag_raddr = frag_base + FA_W'(emit_idx);
    case (state)
      ST_CLEAR: begin
        ctx_we    = 1'b1;
        ctx_waddr = sweep;
        ctx_wdata = '0;
      end
      ST_IDLE: begin
        ctx_raddr = in_ctx;
      end
      ST_LOOK: begin
        if (ftype == frm_pkg::FT_FIRST) begin
          ctx_we = 1'b1;
          if (first_ok) begin
            ctx_wdata.valid         = 1'b1;
            ctx_wdata.command       = cmd;
            ctx_wdata.expected      = FC_W'(fcount);
            ctx_wdata.received      = FC_W'(1);
            ctx_wdata.direction     = dir;
            ctx_wdata.last_activity = time_now;
            frag_we                 = 1'b1;
          end else begin
            ctx_wdata.valid = 1'b0;
          end
        end else if (cw.valid) begin
          ctx_we = 1'b1;
          if (cw.command != cmd) begin
            ctx_wdata.valid = 1'b0;
          end else if (ftype == frm_pkg::FT_MIDDLE) begin
            if (mid_over) begin
              ctx_wdata.valid = 1'b0;
            end else begin
              ctx_wdata.received      = r_next;
              ctx_wdata.last_activity = time_now;
              frag_we                 = 1'b1;
              frag_waddr              = frag_base + FA_W'(r_next - FC_W'(1));
            end
          end else begin
            // Last frame always closes the context
            ctx_wdata.valid = 1'b0;
          end
        end
      end
      ST_PURGE_RD: begin
        ctx_raddr = sweep;
      end
      ST_PURGE_CHK: begin
        ctx_we          = stale;
        ctx_waddr       = sweep;
        ctx_wdata.valid = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      sweep    <= '0;
      time_now <= '0;
      ov       <= 1'b0;
    end else begin
      if (ov && out_ch.ready) begin
        ov <= 1'b0;
      end
      if (load_out) begin
        ov <= 1'b1;
      end
      case (state)
        ST_CLEAR: begin
          sweep <= sweep + CTX_W'(1);
          if (sweep == CTX_W'(NUM_CONTEXTS - 1)) begin
            sweep <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            case (in_ch.op)
              frm_pkg::OP_TICK: begin
                time_now <= time_now + 32'd1;
              end
              frm_pkg::OP_PURGE: begin
                sweep <= '0;
                state <= ST_PURGE_RD;
              end
              frm_pkg::OP_FRAME: begin
                emit_dir <= in_ch.direction;
                state <= (in_ch.fragment_type == frm_pkg::FT_SINGLE) ? ST_FINAL : ST_LOOK;
              end
              default: begin
              end
            endcase
          end
        end
        ST_LOOK: begin
          state <= ST_IDLE;
          if (ftype == frm_pkg::FT_LAST && cw.valid && cw.command == cmd && last_ok) begin
            emit_cnt <= r_next - FC_W'(1);
            emit_idx <= '0;
            emit_dir <= cw.direction;
            state    <= (r_next == FC_W'(1)) ? ST_FINAL : ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          if (out_free) begin
            state <= ST_EMIT_WR;
          end
        end
        ST_EMIT_WR: begin
          emit_idx <= emit_idx + FC_W'(1);
          state    <= (emit_idx + FC_W'(1) == emit_cnt) ? ST_FINAL : ST_EMIT_RD;
        end
        ST_FINAL: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_PURGE_RD: begin
          state <= ST_PURGE_CHK;
        end
        ST_PURGE_CHK: begin
          sweep <= sweep + CTX_W'(1);
          state <= ST_PURGE_RD;
          if (sweep == CTX_W'(NUM_CONTEXTS - 1)) begin
            sweep <= '0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Latch the request and load results; the identity fields travel with the
  // result so a request accepted while it waits leaves it untouched
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ftype   <= in_ch.fragment_type;
      dir     <= in_ch.direction;
      board   <= in_ch.board_address;
      dev     <= in_ch.device_id;
      cmd     <= in_ch.command;
      fcount  <= in_ch.fragment_count;
      payload <= in_ch.payload;
      len     <= in_ch.data_len;
      ctx_idx <= in_ctx;
    end
    if (load_out) begin
      o_dir   <= emit_dir;
      o_board <= board;
      o_dev   <= dev;
      o_cmd   <= cmd;
      if (state == ST_EMIT_WR) begin
        o_data  <= frag_rdata[63:0];
        o_count <= frag_rdata[67:64];
        o_last  <= 1'b0;
      end else begin
        o_data  <= frm_pkg::keep_bytes(payload, trim);
        o_count <= trim;
        o_last  <= 1'b1;
      end
    end
  end

  assign out_ch.valid             = ov;
  assign out_ch.out_board_address = o_board;
  assign out_ch.out_device_id     = o_dev;
  assign out_ch.out_direction     = o_dir;
  assign out_ch.out_command       = o_cmd;
  assign out_ch.out_data          = o_data;
  assign out_ch.byte_count        = o_count;
  assign out_ch.last              = o_last;

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_timeout <= frm_pkg::STALE_TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == frm_pkg::REG_STALE_TIMEOUT) begin
      stale_timeout <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == frm_pkg::REG_STALE_TIMEOUT) ? {16'b0, stale_timeout} : 32'b0;

  `FRM_ASSERT(a_emit_in_range, (state == ST_EMIT_RD) |-> (emit_idx < emit_cnt), "emit index past count")
  `FRM_ASSERT(a_load_free, load_out |-> out_free, "result loaded over a waiting result")
  `FRM_ASSERT(a_clear_blocks, (state == ST_CLEAR) |-> !in_ch.ready, "request taken during clearing pass")

endmodule

### sim/frm_scoreboard.sv
// ----------------------------------------------------------------------------
// frm_scoreboard
// Watches both request channels and the APB port of the reassembler. It keeps
// its own copy of the reassembly contexts, predicts the delivered fragments
// and compares each one, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module frm_scoreboard (
  input  logic        clk,
  input  logic        rst,
  frm_in_if           in_mon,
  frm_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  localparam int NCTX = frm_pkg::NUM_CONTEXTS_DEF;
  localparam int NFRG = frm_pkg::MAX_FRAGMENTS_DEF;

  typedef struct packed {
    logic [2:0]  board;
    logic [2:0]  dev;
    logic        dir;
    logic [7:0]  cmd;
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
  } delivery_t;

  delivery_t   deliveries_q[$];

  logic        ctx_open [NCTX];
  logic [7:0]  ctx_cmd [NCTX];
  int          ctx_expected [NCTX];
  int          ctx_received [NCTX];
  logic        ctx_dir [NCTX];
  logic [31:0] ctx_touched [NCTX];
  logic [63:0] frag_data [NCTX][NFRG];
  logic [3:0]  frag_len [NCTX][NFRG];
  logic [31:0] tick_count;
  logic [15:0] idle_limit;

  function automatic logic [63:0] trim_bytes(input logic [63:0] d, input int n);
    if (n >= 8) return d;
    return d & ((64'd1 << (n * 8)) - 64'd1);
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic push(input logic [2:0] b, input logic [2:0] dv, input logic dr,
                      input logic [7:0] c, input logic [63:0] d, input int n, input logic l);
    delivery_t e;
    e = '{board: b, dev: dv, dir: dr, cmd: c, data: d, cnt: 4'(n), last: l};
    deliveries_q.push_back(e);
  endtask

  // Apply one accepted request to the context copy and queue its deliveries.
  task automatic predict_request();
    int len, trim, ctx, r;
    len  = (in_mon.data_len > 4'd8) ? 8 : int'(in_mon.data_len);
    trim = (int'(in_mon.fragment_count) < len) ? int'(in_mon.fragment_count) : len;
    ctx  = int'({in_mon.board_address, in_mon.device_id}) % NCTX;
    if (in_mon.op == frm_pkg::OP_TICK) begin
      tick_count++;
    end else if (in_mon.op == frm_pkg::OP_PURGE) begin
      for (int i = 0; i < NCTX; i++) begin
        if (ctx_open[i] && (tick_count - ctx_touched[i]) > {16'd0, idle_limit})
          ctx_open[i] = 1'b0;
      end
    end else if (in_mon.op == frm_pkg::OP_FRAME) begin
      if (in_mon.fragment_type == frm_pkg::FT_SINGLE) begin
        push(in_mon.board_address, in_mon.device_id, in_mon.direction, in_mon.command,
             trim_bytes(in_mon.payload, trim), trim, 1'b1);
      end else if (in_mon.fragment_type == frm_pkg::FT_FIRST) begin
        ctx_open[ctx] = 1'b0;
        if (int'(in_mon.fragment_count) <= NFRG) begin
          ctx_open[ctx]     = 1'b1;
          ctx_cmd[ctx]      = in_mon.command;
          ctx_expected[ctx] = int'(in_mon.fragment_count);
          ctx_received[ctx] = 1;
          ctx_dir[ctx]      = in_mon.direction;
          ctx_touched[ctx]  = tick_count;
          frag_data[ctx][0] = trim_bytes(in_mon.payload, len);
          frag_len[ctx][0]  = 4'(len);
        end
      end else if (ctx_open[ctx]) begin
        if (ctx_cmd[ctx] != in_mon.command) begin
          ctx_open[ctx] = 1'b0;
        end else begin
          ctx_received[ctx]++;
          r = ctx_received[ctx];
          if (in_mon.fragment_type == frm_pkg::FT_MIDDLE) begin
            if (r > ctx_expected[ctx] || r > NFRG) begin
              ctx_open[ctx] = 1'b0;
            end else begin
              frag_data[ctx][r-1] = trim_bytes(in_mon.payload, len);
              frag_len[ctx][r-1]  = 4'(len);
              ctx_touched[ctx]    = tick_count;
            end
          end else begin
            ctx_open[ctx] = 1'b0;
            if (r == ctx_expected[ctx] && r <= NFRG && r >= 1) begin
              for (int i = 0; i + 1 < r; i++)
                push(in_mon.board_address, in_mon.device_id, ctx_dir[ctx], in_mon.command,
                     frag_data[ctx][i], int'(frag_len[ctx][i]), 1'b0);
              push(in_mon.board_address, in_mon.device_id, ctx_dir[ctx], in_mon.command,
                   trim_bytes(in_mon.payload, trim), trim, 1'b1);
            end
          end
        end
      end
    end
  endtask

  task automatic check_delivery();
    delivery_t e;
    if (deliveries_q.size() == 0) begin
      report("unexpected delivery", out_mon.out_data, 64'd0);
      return;
    end
    e = deliveries_q.pop_front();
    checked++;
    if (out_mon.out_board_address != e.board) report("board", out_mon.out_board_address, e.board);
    if (out_mon.out_device_id != e.dev)       report("device", out_mon.out_device_id, e.dev);
    if (out_mon.out_direction != e.dir)       report("direction", out_mon.out_direction, e.dir);
    if (out_mon.out_command != e.cmd)         report("command", out_mon.out_command, e.cmd);
    if (out_mon.out_data != e.data)           report("data", out_mon.out_data, e.data);
    if (out_mon.byte_count != e.cnt)          report("byte_count", out_mon.byte_count, e.cnt);
    if (out_mon.last != e.last)               report("last", out_mon.last, e.last);
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCTX; i++) ctx_open[i] = 1'b0;
      tick_count = '0;
      idle_limit = frm_pkg::STALE_TIMEOUT_RST;
      deliveries_q.delete();
    end else begin
      // Deliveries never stem from a request accepted at the same edge.
      if (out_mon.valid && out_mon.ready) check_delivery();
      if (in_mon.valid && in_mon.ready) predict_request();
    end
    // The APB port takes writes during the clearing pass as well.
    if (psel && penable && pwrite && paddr[2] == frm_pkg::REG_STALE_TIMEOUT)
      idle_limit = pwdata[15:0];
    pending = deliveries_q.size();
  end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the reassembler bench: clock, reset, request stimulus, APB writes of
// stale_timeout and the verdict. Prediction and checking live in the
// scoreboard instantiated beside the block.
// ----------------------------------------------------------------------------
module tb;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          checked;
  int          sent;
  bit          quiet;       // no idling on either side while set
  bit          stall_req;   // ask the receiver for one long hold-off

  frm_in_if  in_ch ();
  frm_out_if out_ch ();

  fragment_message_reassembler dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frm_scoreboard scoreboard (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #(20 * 600000);
    $display("[fragment_message_reassembler] ERROR");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
      end
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offer one request and hold it until accepted; idle afterwards at random.
  task automatic send_req(input logic [1:0] op, input logic [1:0] ft, input logic dir,
                          input logic [2:0] board, input logic [2:0] dev,
                          input logic [7:0] cmd, input logic [7:0] fcount,
                          input logic [63:0] payload, input logic [3:0] len);
    int gap;
    in_ch.valid          <= 1'b1;
    in_ch.op             <= op;
    in_ch.fragment_type  <= ft;
    in_ch.direction      <= dir;
    in_ch.board_address  <= board;
    in_ch.device_id      <= dev;
    in_ch.command        <= cmd;
    in_ch.fragment_count <= fcount;
    in_ch.payload        <= payload;
    in_ch.data_len       <= len;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (!quiet && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [1:0] ft, input logic dir, input logic [5:0] key,
                            input logic [7:0] cmd, input logic [7:0] fcount);
    send_req(frm_pkg::OP_FRAME, ft, dir, key[5:3], key[2:0], cmd, fcount, rand_word(),
             4'($urandom_range(0, 9)));
  endtask

  // Send a first frame expecting n, then the given middles, then a last.
  // Corrupt the last command when bad_cmd is set.
  task automatic send_message(input logic [5:0] key, input int n, input int middles,
                              input bit bad_cmd);
    logic [7:0] cmd;
    logic       dir;
    cmd = 8'($urandom);
    dir = 1'($urandom);
    send_frame(frm_pkg::FT_FIRST, dir, key, cmd, 8'(n));
    for (int i = 0; i < middles; i++) begin
      if ($urandom_range(19) == 0)
        send_req(frm_pkg::OP_TICK, 2'($urandom), 1'b0, 3'd0, 3'd0, 8'd0, 8'd0, 64'd0, 4'd0);
      send_frame(frm_pkg::FT_MIDDLE, 1'($urandom), key, cmd, 8'($urandom));
    end
    send_frame(frm_pkg::FT_LAST, 1'($urandom), key, bad_cmd ? ~cmd : cmd,
               8'($urandom_range(0, 10)));
  endtask

  // Drain every expected delivery, then let a purge pass finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2 * frm_pkg::NUM_CONTEXTS_DEF + 20) @(posedge clk);
  endtask

  task automatic apb_write(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'd0;
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int pick;
    int n;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // Well-formed message, mostly short, now and then the longest.
        n = ($urandom_range(9) == 0) ? 16 : $urandom_range(2, 5);
        send_message(6'($urandom), n, n - 2, 1'b0);
      end else if (pick < 65) begin
        // Broken message: wrong middle count or command.
        send_message(6'($urandom), $urandom_range(0, 17), $urandom_range(0, 4),
                     $urandom_range(3) == 0);
      end else if (pick < 75) begin
        send_frame(frm_pkg::FT_SINGLE, 1'($urandom), 6'($urandom), 8'($urandom),
                   8'($urandom));
      end else if (pick < 85) begin
        send_req(frm_pkg::OP_TICK, 2'($urandom), 1'($urandom), 3'($urandom), 3'($urandom),
                 8'($urandom), 8'($urandom), rand_word(), 4'($urandom));
      end else if (pick < 90) begin
        send_req(frm_pkg::OP_PURGE, 2'($urandom), 1'($urandom), 3'($urandom), 3'($urandom),
                 8'($urandom), 8'($urandom), rand_word(), 4'($urandom));
      end else begin
        // Noise: any field value, unused op included.
        send_req(2'($urandom), 2'($urandom), 1'($urandom), 3'($urandom), 3'($urandom),
                 8'($urandom), 8'($urandom), rand_word(), 4'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] cmd;
    sent      = 0;
    quiet     = 1'b0;
    stall_req = 1'b0;
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= 3'd0;
    pwdata       <= 32'd0;
    in_ch.valid  <= 1'b0;
    in_ch.op             <= frm_pkg::OP_TICK;
    in_ch.fragment_type  <= frm_pkg::FT_SINGLE;
    in_ch.direction      <= 1'b0;
    in_ch.board_address  <= 3'd0;
    in_ch.device_id      <= 3'd0;
    in_ch.command        <= 8'd0;
    in_ch.fragment_count <= 8'd0;
    in_ch.payload        <= 64'd0;
    in_ch.data_len       <= 4'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    apb_write(16'd100);

    // Directed: single frame extremes and trims.
    send_req(frm_pkg::OP_FRAME, frm_pkg::FT_SINGLE, 1'b1, 3'd7, 3'd7, 8'hFF, 8'hFF, '1, 4'd8);
    send_req(frm_pkg::OP_FRAME, frm_pkg::FT_SINGLE, 1'b0, 3'd0, 3'd0, 8'h00, 8'd0, '1, 4'd8);
    send_req(frm_pkg::OP_FRAME, frm_pkg::FT_SINGLE, 1'b1, 3'd3, 3'd5, 8'h5A, 8'd3, '1, 4'd15);
    send_req(frm_pkg::OP_FRAME, frm_pkg::FT_SINGLE, 1'b0, 3'd1, 3'd2, 8'hA5, 8'd8, '1, 4'd0);
    // Unused op, tick, purge.
    send_req(frm_pkg::OP_RESERVED, frm_pkg::FT_FIRST, 1'b1, 3'd7, 3'd7, 8'hFF, 8'hFF, '1,
             4'd15);
    send_req(frm_pkg::OP_TICK, frm_pkg::FT_LAST, 1'b0, 3'd0, 3'd0, 8'd0, 8'd0, 64'd0, 4'd0);
    send_req(frm_pkg::OP_PURGE, frm_pkg::FT_LAST, 1'b0, 3'd0, 3'd0, 8'd0, 8'd0, 64'd0, 4'd0);
    // Middle and last with no open context.
    send_frame(frm_pkg::FT_MIDDLE, 1'b0, 6'd9, 8'h11, 8'd2);
    send_frame(frm_pkg::FT_LAST, 1'b1, 6'd9, 8'h11, 8'd2);
    // Too many fragments expected: dropped.
    send_frame(frm_pkg::FT_FIRST, 1'b1, 6'd10, 8'h22, 8'd17);
    send_frame(frm_pkg::FT_LAST, 1'b1, 6'd10, 8'h22, 8'd4);
    // Longest message, zero-byte final fragment, full-width key.
    cmd = 8'hC3;
    send_req(frm_pkg::OP_FRAME, frm_pkg::FT_FIRST, 1'b1, 3'd7, 3'd7, cmd, 8'd16, '1, 4'd8);
    for (int i = 0; i < 14; i++) send_frame(frm_pkg::FT_MIDDLE, 1'b0, 6'd63, cmd, 8'd0);
    send_req(frm_pkg::OP_FRAME, frm_pkg::FT_LAST, 1'b0, 3'd7, 3'd7, cmd, 8'd0, '1, 4'd8);
    // Command mismatch, overrun, wrong count, first expecting one.
    send_message(6'd1, 3, 1, 1'b1);
    send_message(6'd2, 2, 2, 1'b0);
    send_message(6'd3, 4, 1, 1'b0);
    send_message(6'd4, 1, 0, 1'b0);
    send_message(6'd0, 0, 0, 1'b0);
    drain();

    // Pressure: hold the receiver off while long messages keep coming.
    stall_req = 1'b1;
    for (int i = 0; i < 4; i++) send_message(6'($urandom), 16, 14, 1'b0);
    drain();

    // Random phases across timeout settings, extremes included.
    apb_write(16'd0);
    random_phase(10);
    drain();
    apb_write(16'hFFFF);
    quiet = 1'b1;
    random_phase(8);
    quiet = 1'b0;
    drain();
    apb_write(16'd3);
    random_phase(10);
    drain();
    apb_write(16'd100);
    while (sent < 210) random_phase(1);

    // Wait out every delivery and the tail of the block's work.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2 * frm_pkg::NUM_CONTEXTS_DEF + 40) @(posedge clk);

    $display("covered %0d requests, %0d deliveries checked", sent, checked);
    $display("timeouts 100, 0, 65535 and 3; long receiver hold-off; broken messages");
    if (fail_count == 0) begin
      $display("[fragment_message_reassembler] OK");
    end else begin
      $display("[fragment_message_reassembler] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/frm_pkg.sv
sv/frm_in_if.sv
sv/frm_out_if.sv
sv/frm_ram.sv
sv/fragment_message_reassembler.sv
sim/frm_scoreboard.sv
sim/tb.sv
